// ===== sv/swrr_pkg.sv =====
package swrr_pkg;

    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int COUNT_W   = 5;
    localparam int RUN_BITS  = 22;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_SELECT       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_STATIC  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_DYNAMIC = 2'd2;

    typedef enum logic [1:0] {
        OP_SELECT,
        OP_LOAD_STATIC,
        OP_LOAD_DYNAMIC
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] weight;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_peer;
        logic             found;
    } t_result;

endpackage

// ===== sv/swrr_ram.sv =====
module swrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/swrr_fifo.sv =====
module swrr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_data[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ===== sv/swrr_front.sv =====
module swrr_front #(
    parameter int MAX_PEERS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [swrr_pkg::FUNC_W-1:0]     i_func,
    input  logic [swrr_pkg::IDX_W-1:0]      i_peer_index,
    input  logic [swrr_pkg::WEIGHT_W-1:0]   i_weight_value,
    output logic                            o_full,
    output swrr_pkg::t_cmd                  o_cmd,
    output logic                            o_cmd_empty,
    input  logic                            i_cmd_pop
);

    import swrr_pkg::*;

    t_cmd                 cmd;
    logic                 keep;
    logic                 in_range;
    logic [$bits(t_cmd)-1:0] cmd_q;

    assign in_range = (32'(i_peer_index) < MAX_PEERS);

    always_comb begin
        cmd.idx    = i_peer_index;
        cmd.weight = i_weight_value;
        cmd.op     = OP_SELECT;
        keep       = 1'b0;
        case (i_func)
            FUNC_SELECT: begin
                cmd.op = OP_SELECT;
                keep   = 1'b1;
            end
            FUNC_LOAD_STATIC: begin
                cmd.op = OP_LOAD_STATIC;
                keep   = in_range;
            end
            FUNC_LOAD_DYNAMIC: begin
                cmd.op = OP_LOAD_DYNAMIC;
                keep   = in_range;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    swrr_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_wdata (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (cmd_q),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(cmd_q);

endmodule

// ===== sv/swrr_engine.sv =====
module swrr_engine #(
    parameter int MAX_PEERS   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [swrr_pkg::COUNT_W-1:0]   i_peer_count,
    input  swrr_pkg::t_cmd                 i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_push,
    output swrr_pkg::t_result              o_res
);

    import swrr_pkg::*;

    localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam int WB = WEIGHT_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINAL
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_rd_cnt, n_rd_cnt;
    logic                  r_pv, n_pv;
    logic [AW-1:0]         r_pv_idx, n_pv_idx;
    logic                  r_have, n_have;
    logic [AW-1:0]         r_best, n_best;
    logic [RUN_BITS-1:0]   r_best_run, n_best_run;
    logic [RUN_BITS-1:0]   r_total, n_total;
    logic [MAX_PEERS-1:0]  r_v_nom, r_v_eff, r_v_run;

    logic [CW-1:0]         n_peers;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic                  nom_we, eff_we, run_we;
    logic [WB-1:0]         nom_wdata, eff_wdata;
    logic [RUN_BITS-1:0]   run_wdata;
    logic [WB-1:0]         nom_rdata, eff_rdata;
    logic [RUN_BITS-1:0]   run_rdata;
    logic [WB-1:0]         nom_q, eff_q;
    logic [RUN_BITS-1:0]   run_q;
    logic [RUN_BITS-1:0]   new_run;
    logic [WB+WEIGHT_W-1:0]   w_wide;
    logic [WB-1:0]            w_in;
    logic [AW+IDX_W-1:0]      idx_wide;
    logic [AW-1:0]            cmd_addr;
    logic [RUN_BITS+WB-1:0]   eff_wide;
    logic [RUN_BITS-1:0]      eff_run;
    logic [IDX_W+AW-1:0]      best_wide;

    assign n_peers  = (32'(i_peer_count) > MAX_PEERS) ? CW'(MAX_PEERS) : CW'(i_peer_count);
    assign w_wide   = {{WB{1'b0}}, i_cmd.weight};
    assign w_in     = w_wide[WB-1:0];
    assign idx_wide = {{AW{1'b0}}, i_cmd.idx};
    assign cmd_addr = idx_wide[AW-1:0];
    assign raddr    = r_rd_cnt[AW-1:0];

    assign nom_q    = r_v_nom[r_pv_idx] ? nom_rdata : '0;
    assign eff_q    = r_v_eff[r_pv_idx] ? eff_rdata : '0;
    assign run_q    = r_v_run[r_pv_idx] ? run_rdata : '0;
    assign eff_wide = {{RUN_BITS{1'b0}}, eff_q};
    assign eff_run  = eff_wide[RUN_BITS-1:0];
    assign new_run  = run_q + eff_run;
    assign best_wide = {{IDX_W{1'b0}}, r_best};

    always_comb begin
        n_state    = r_state;
        n_rd_cnt   = r_rd_cnt;
        n_pv       = r_pv;
        n_pv_idx   = r_pv_idx;
        n_have     = r_have;
        n_best     = r_best;
        n_best_run = r_best_run;
        n_total    = r_total;
        waddr      = cmd_addr;
        nom_we     = 1'b0;
        eff_we     = 1'b0;
        run_we     = 1'b0;
        nom_wdata  = w_in;
        eff_wdata  = w_in;
        run_wdata  = '0;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.chosen_peer = '0;
        o_res.found       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.op)
                        OP_LOAD_STATIC: begin
                            nom_we    = 1'b1;
                            eff_we    = 1'b1;
                            run_we    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_LOAD_DYNAMIC: begin
                            eff_we    = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_SELECT: begin
                            if (!i_res_full) begin
                                if (n_peers == '0) begin
                                    o_res_push = 1'b1;
                                    o_cmd_pop  = 1'b1;
                                end else begin
                                    n_state  = S_WALK;
                                    n_rd_cnt = '0;
                                    n_pv     = 1'b0;
                                    n_have   = 1'b0;
                                    n_total  = '0;
                                end
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_rd_cnt != n_peers) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                    n_pv     = 1'b1;
                    n_pv_idx = raddr;
                end else begin
                    n_pv    = 1'b0;
                    n_state = S_FINAL;
                end
                if (r_pv) begin
                    waddr     = r_pv_idx;
                    run_we    = 1'b1;
                    run_wdata = new_run;
                    eff_we    = (eff_q < nom_q);
                    eff_wdata = eff_q + 1'b1;
                    n_total   = r_total + eff_run;
                    if (!r_have || ($signed(new_run) > $signed(r_best_run))) begin
                        n_have     = 1'b1;
                        n_best     = r_pv_idx;
                        n_best_run = new_run;
                    end
                end
            end
            S_FINAL: begin
                waddr      = r_best;
                run_we     = 1'b1;
                run_wdata  = r_best_run - r_total;
                o_res_push = 1'b1;
                o_res.chosen_peer = best_wide[IDX_W-1:0];
                o_res.found       = 1'b1;
                o_cmd_pop  = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_have  <= 1'b0;
            r_v_nom <= '0;
            r_v_eff <= '0;
            r_v_run <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_have  <= n_have;
            if (nom_we) begin
                r_v_nom[waddr] <= 1'b1;
            end
            if (eff_we) begin
                r_v_eff[waddr] <= 1'b1;
            end
            if (run_we) begin
                r_v_run[waddr] <= 1'b1;
            end
        end
        r_rd_cnt   <= n_rd_cnt;
        r_pv_idx   <= n_pv_idx;
        r_best     <= n_best;
        r_best_run <= n_best_run;
        r_total    <= n_total;
    end

    swrr_ram #(
        .WIDTH (WB),
        .DEPTH (MAX_PEERS)
    ) u_nom_ram (
        .i_clk   (i_clk),
        .i_we    (nom_we),
        .i_waddr (waddr),
        .i_wdata (nom_wdata),
        .i_raddr (raddr),
        .o_rdata (nom_rdata)
    );

    swrr_ram #(
        .WIDTH (WB),
        .DEPTH (MAX_PEERS)
    ) u_eff_ram (
        .i_clk   (i_clk),
        .i_we    (eff_we),
        .i_waddr (waddr),
        .i_wdata (eff_wdata),
        .i_raddr (raddr),
        .o_rdata (eff_rdata)
    );

    swrr_ram #(
        .WIDTH (RUN_BITS),
        .DEPTH (MAX_PEERS)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (waddr),
        .i_wdata (run_wdata),
        .i_raddr (raddr),
        .o_rdata (run_rdata)
    );

endmodule

// ===== sv/smooth_weighted_round_robin.sv =====
// Channel   Direction  Handshake            Payload
// input     in         push / full          i_func, i_peer_index, i_weight_value
// result    out        pop / empty          o_chosen_peer, o_found
// config    in         i_cfg_we             i_cfg_wdata (peer count)
//
// A weight load is taken in the engine's idle state; a select walks the weight memories
// with one read per peer for n peers, n being the peer count clamped to MAX_PEERS, then
// writes back the chosen peer's running weight in a final state; with no peers it returns o_found low.
// Reset clears the peer count and all weights at once through per-entry valid bits.
// Two-entry queues sit before and after the engine, so each side stalls on its own;
// a select waits in the engine only while the result queue is full.
module smooth_weighted_round_robin #(
    parameter int MAX_PEERS   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [swrr_pkg::FUNC_W-1:0]     i_func,
    input  logic [swrr_pkg::IDX_W-1:0]      i_peer_index,
    input  logic [swrr_pkg::WEIGHT_W-1:0]   i_weight_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [swrr_pkg::IDX_W-1:0]      o_chosen_peer,
    output logic                            o_found,
    input  logic                            i_cfg_we,
    input  logic [swrr_pkg::COUNT_W-1:0]    i_cfg_wdata
);

    import swrr_pkg::*;

    logic [COUNT_W-1:0]         r_peer_count;
    t_cmd                       cmd;
    logic                       cmd_empty;
    logic                       cmd_pop;
    logic                       res_full;
    logic                       res_push;
    t_result                    res;
    logic [$bits(t_result)-1:0] res_q;
    t_result                    res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer_count <= '0;
        end else if (i_cfg_we) begin
            r_peer_count <= i_cfg_wdata;
        end
    end

    swrr_front #(
        .MAX_PEERS (MAX_PEERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_func         (i_func),
        .i_peer_index   (i_peer_index),
        .i_weight_value (i_weight_value),
        .o_full         (full),
        .o_cmd          (cmd),
        .o_cmd_empty    (cmd_empty),
        .i_cmd_pop      (cmd_pop)
    );

    swrr_engine #(
        .MAX_PEERS   (MAX_PEERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_peer_count (r_peer_count),
        .i_cmd        (cmd),
        .i_cmd_empty  (cmd_empty),
        .o_cmd_pop    (cmd_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res)
    );

    swrr_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_q),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_q);
    assign o_chosen_peer = res_out.chosen_peer;
    assign o_found       = res_out.found;

endmodule
